// ===== rtl/core/arr_pkg.sv =====
// ----------------------------------------------------------------------------
// arr_pkg - shared definitions of the adaptive range receptor
// Constants, codes, control structs and the exp table generator.
// ----------------------------------------------------------------------------
package arr_pkg;

  localparam int unsigned DECAY_SHIFT_DEF    = 8;
  localparam int unsigned EXP_TABLE_BITS_DEF = 10;

  // shared unit widths: multiplier operand, dividend/product, step counter
  localparam int unsigned MUL_W = 34;
  localparam int unsigned DIV_W = 68;
  localparam int unsigned CNT_W = 7;

  localparam logic [63:0] LN2_Q32    = 64'd2977044472;
  localparam logic [33:0] LOG2E_Q    = 34'd94548;
  localparam logic [33:0] LN_INV09_Q = 34'd6905;

  localparam logic [30:0] GAIN_RST   = 31'd65536;
  localparam logic [31:0] OUT_MIN_RST = 32'd0;
  localparam logic [31:0] OUT_MAX_RST = 32'd65536;
  localparam logic [31:0] CURVE_RST   = 32'd6554;
  localparam logic [31:0] OFFSET_RST  = 32'd65536;
  localparam logic [4:0]  MODE_RST    = 5'd5;
  localparam logic [31:0] START_MIN_RST = 32'd0;
  localparam logic [31:0] START_MAX_RST = 32'd65536;

  typedef enum logic [2:0] {
    CFG_GAIN      = 3'd0,
    CFG_OUT_MIN   = 3'd1,
    CFG_OUT_MAX   = 3'd2,
    CFG_CURVE     = 3'd3,
    CFG_OFFSET    = 3'd4,
    CFG_MODE      = 3'd5,
    CFG_START_MIN = 3'd6,
    CFG_START_MAX = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CRV_LIN     = 3'd0,
    CRV_ONE_EXP = 3'd1,
    CRV_EXP     = 3'd2,
    CRV_AUTO    = 3'd3,
    CRV_OFFSET  = 3'd4,
    CRV_OFF_EXP = 3'd5
  } curve_e;

  typedef enum logic [1:0] {
    IN_FIXED = 2'd0,
    IN_WIDEN = 2'd1,
    IN_DECAY = 2'd2,
    IN_HOLD  = 2'd3
  } in_mode_e;

  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_e;

  typedef struct packed {
    logic    start;
    mdu_op_e op;
  } mdu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RANGE, ST_SCALE_MUL, ST_SCALE_DIV, ST_CURVE, ST_T_MUL,
    ST_K_MUL, ST_K_DIV, ST_LOG_START, ST_LOG_MUL, ST_ROM, ST_EXP,
    ST_GAIN_START, ST_GAIN_MUL, ST_FINISH
  } state_e;

  // 2^(-f) in Q2.30 for f = idx / 2^bits, by a 24 term series
  function automatic logic [31:0] exp_entry(int unsigned idx, int unsigned bits);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] rnd;
    y    = (64'(idx) * LN2_Q32) >> bits;
    term = 64'd1 << 32;
    sum  = term;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * y) >> 32) / 64'(k);
      sum  = (k % 2 == 1) ? sum - term : sum + term;
    end
    rnd = (sum + 64'd2) >> 2;
    return rnd[31:0];
  endfunction

endpackage

// ===== rtl/core/adaptive_range_receptor_top.sv =====
// ----------------------------------------------------------------------------
// adaptive_range_receptor_top - adaptive range receptor
// Tracks an input range, rescales each sample onto the output range and
// applies a gained output curve, saturated to Q16.16.
// ----------------------------------------------------------------------------
// channel  dir  handshake                 payload
// s_axis   in   tvalid/tready             tdata: sample
// m_axis   out  tvalid/tready             tdata: response; tuser: range_empty
// cfg      in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One word at a time; the shared shift-add multiplier / restoring divider
// does the work: a multiply, a divide and the gain multiply for curves 0 and 4,
// two more multiplies for the exp curves, and a multiply, a divide and a
// multiply more for the auto-range curve. A zero range skips the unit.
// A finished word waits in the output register while the next one is taken.
// Reset loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module adaptive_range_receptor_top #(
  parameter int unsigned DECAY_SHIFT    = arr_pkg::DECAY_SHIFT_DEF,
  parameter int unsigned EXP_TABLE_BITS = arr_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] sample
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] response
  output logic [0:0]  m_axis_tuser_o,   // [0] range_empty
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned ROM_DEPTH = 1 << EXP_TABLE_BITS;
  localparam int unsigned DW = arr_pkg::DIV_W;
  localparam int unsigned MW = arr_pkg::MUL_W;

  arr_pkg::state_e state_q, state_d;

  logic [30:0]        gain_q;
  logic signed [31:0] out_min_q, out_max_q, curve_q, offset_q;
  logic [4:0]         mode_q;
  logic signed [31:0] seen_min_q, seen_max_q;
  logic signed [31:0] s_q, x_q;
  logic               t_neg_q;
  logic [33:0]        t_mag_q;
  logic signed [35:0] u_q;
  logic [31:0]        rom_q;
  logic signed [33:0] inner_q;
  logic [31:0]        res_q;
  logic               empty_q;
  logic               out_valid_q;
  logic [31:0]        out_data_q;
  logic               out_user_q;

  logic [31:0] exp_rom [ROM_DEPTH];

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic [31:0] ENTRY = arr_pkg::exp_entry(g, EXP_TABLE_BITS);
    assign exp_rom[g] = ENTRY;
  end

  arr_pkg::mdu_req_t mdu_req;
  arr_pkg::mdu_rsp_t mdu_rsp;
  logic [DW-1:0]     mdu_a, mdu_res;
  logic [MW-1:0]     mdu_b;

  arr_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .a_i    (mdu_a),
    .b_i    (mdu_b),
    .rsp_o  (mdu_rsp),
    .res_o  (mdu_res)
  );

  // mode decode
  arr_pkg::in_mode_e in_mode;
  arr_pkg::curve_e   curve;

  always_comb begin
    if (mode_q < 5'd6) begin
      in_mode = arr_pkg::IN_FIXED;
      curve   = arr_pkg::curve_e'(mode_q[2:0]);
    end else if (mode_q < 5'd12) begin
      in_mode = arr_pkg::IN_WIDEN;
      curve   = arr_pkg::curve_e'(3'(mode_q - 5'd6));
    end else if (mode_q < 5'd18) begin
      in_mode = arr_pkg::IN_DECAY;
      curve   = arr_pkg::curve_e'(3'(mode_q - 5'd12));
    end else if (mode_q < 5'd24) begin
      in_mode = arr_pkg::IN_HOLD;
      curve   = arr_pkg::curve_e'(3'(mode_q - 5'd18));
    end else if (mode_q < 5'd30) begin
      in_mode = arr_pkg::IN_HOLD;
      curve   = arr_pkg::curve_e'(3'(mode_q - 5'd24));
    end else begin
      in_mode = arr_pkg::IN_HOLD;
      curve   = arr_pkg::curve_e'(3'(mode_q - 5'd30));
    end
  end

  // range tracking at accept
  logic               s_acc;
  logic signed [31:0] s_in, new_min, new_max;

  assign s_acc = s_axis_tvalid_i & s_axis_tready_o;
  assign s_in  = $signed(s_axis_tdata_i);

  always_comb begin
    new_min = seen_min_q;
    new_max = seen_max_q;
    case (in_mode)
      arr_pkg::IN_WIDEN: begin
        if (s_in < seen_min_q) new_min = s_in;
        if (s_in > seen_max_q) new_max = s_in;
      end
      arr_pkg::IN_DECAY: begin
        new_min = (s_in < seen_min_q) ? s_in : seen_min_q - (seen_min_q >>> DECAY_SHIFT);
        new_max = (s_in > seen_max_q) ? s_in : seen_max_q - (seen_max_q >>> DECAY_SHIFT);
      end
      default: ;
    endcase
  end

  // datapath terms
  logic [32:0] rng, num, outr, rng_mag, num_mag, outr_mag;
  logic        scale_neg;
  logic [DW-1:0] rnd;
  logic [51:0] rmag;
  logic        q_over;
  logic [40:0] q_cap;
  logic [42:0] x_sum;
  logic signed [31:0] x_sat;
  logic [31:0] x_mag, k_mag;
  logic [33:0] inner_mag;

  assign rng  = {seen_max_q[31], seen_max_q} - {seen_min_q[31], seen_min_q};
  assign num  = {s_q[31], s_q} - {seen_min_q[31], seen_min_q};
  assign outr = {out_max_q[31], out_max_q} - {out_min_q[31], out_min_q};
  assign rng_mag  = rng[32] ? -rng : rng;
  assign num_mag  = num[32] ? -num : num;
  assign outr_mag = outr[32] ? -outr : outr;
  assign scale_neg = num[32] ^ outr[32] ^ rng[32];

  assign rnd  = mdu_res + DW'(32'h8000);
  assign rmag = rnd[DW-1:16];

  assign q_over = (|mdu_res[DW-1:41]) | (mdu_res[40] & (|mdu_res[39:0]));
  assign q_cap  = q_over ? {1'b1, 40'd0} : mdu_res[40:0];

  always_comb begin
    x_sum = scale_neg ? {{11{out_min_q[31]}}, out_min_q} - {2'b00, q_cap}
                      : {{11{out_min_q[31]}}, out_min_q} + {2'b00, q_cap};
    if (!x_sum[42] && (|x_sum[41:31])) x_sat = 32'sh7fff_ffff;
    else if (x_sum[42] && !(&x_sum[41:31])) x_sat = 32'sh8000_0000;
    else x_sat = $signed(x_sum[31:0]);
  end

  assign x_mag     = x_q[31] ? 32'(-x_q) : 32'(x_q);
  assign k_mag     = curve_q[31] ? 32'(-curve_q) : 32'(curve_q);
  assign inner_mag = inner_q[33] ? 34'(-inner_q) : 34'(inner_q);

  // exp from table entry and integer part
  logic signed [19:0] nh, neg_m;
  logic [5:0]  sh_lo;
  logic [32:0] pos_sum, pos_val;
  logic [51:0] neg_val;
  logic [30:0] e_val;
  logic signed [33:0] c_ext, e_ext;

  assign nh      = u_q[35:16];
  assign neg_m   = -nh;
  assign sh_lo   = 6'(nh[4:0]) + 6'd13;
  assign pos_sum = {1'b0, rom_q} + (33'd1 << sh_lo);
  assign pos_val = pos_sum >> (sh_lo + 6'd1);
  assign neg_val = ((52'(rom_q) << neg_m[4:0]) + 52'd8192) >> 14;

  always_comb begin
    if (!nh[19]) begin
      e_val = (nh[18:0] >= 19'd18) ? 31'd0 : pos_val[30:0];
    end else if (neg_m > 20'sd20) begin
      e_val = '1;
    end else if (|neg_val[51:31]) begin
      e_val = '1;
    end else begin
      e_val = neg_val[30:0];
    end
  end

  assign c_ext = 34'(offset_q);
  assign e_ext = $signed({3'b000, e_val});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      arr_pkg::ST_IDLE:      if (s_acc) state_d = arr_pkg::ST_RANGE;
      arr_pkg::ST_RANGE:     state_d = (rng == '0) ? arr_pkg::ST_FINISH : arr_pkg::ST_SCALE_MUL;
      arr_pkg::ST_SCALE_MUL: if (mdu_rsp.done) state_d = arr_pkg::ST_SCALE_DIV;
      arr_pkg::ST_SCALE_DIV: if (mdu_rsp.done) state_d = arr_pkg::ST_CURVE;
      arr_pkg::ST_CURVE: begin
        case (curve)
          arr_pkg::CRV_LIN, arr_pkg::CRV_OFFSET: state_d = arr_pkg::ST_GAIN_START;
          arr_pkg::CRV_AUTO: state_d = arr_pkg::ST_K_MUL;
          default: state_d = arr_pkg::ST_T_MUL;
        endcase
      end
      arr_pkg::ST_T_MUL:      if (mdu_rsp.done) state_d = arr_pkg::ST_LOG_START;
      arr_pkg::ST_K_MUL:      if (mdu_rsp.done) state_d = arr_pkg::ST_K_DIV;
      arr_pkg::ST_K_DIV:      if (mdu_rsp.done) state_d = arr_pkg::ST_LOG_START;
      arr_pkg::ST_LOG_START:  state_d = arr_pkg::ST_LOG_MUL;
      arr_pkg::ST_LOG_MUL:    if (mdu_rsp.done) state_d = arr_pkg::ST_ROM;
      arr_pkg::ST_ROM:        state_d = arr_pkg::ST_EXP;
      arr_pkg::ST_EXP:        state_d = arr_pkg::ST_GAIN_START;
      arr_pkg::ST_GAIN_START: state_d = arr_pkg::ST_GAIN_MUL;
      arr_pkg::ST_GAIN_MUL:   if (mdu_rsp.done) state_d = arr_pkg::ST_FINISH;
      arr_pkg::ST_FINISH:     if (!out_valid_q || m_axis_tready_i) state_d = arr_pkg::ST_IDLE;
      default:                state_d = arr_pkg::ST_IDLE;
    endcase
  end

  // unit requests and handshakes
  always_comb begin
    mdu_req.start = 1'b0;
    mdu_req.op    = arr_pkg::MDU_MUL;
    mdu_a         = '0;
    mdu_b         = '0;
    case (state_q)
      arr_pkg::ST_RANGE: begin
        if (rng != '0) begin
          mdu_req.start = 1'b1;
          mdu_a = DW'(num_mag);
          mdu_b = MW'(outr_mag);
        end
      end
      arr_pkg::ST_SCALE_MUL, arr_pkg::ST_K_MUL: begin
        if (mdu_rsp.done) begin
          mdu_req.start = 1'b1;
          mdu_req.op    = arr_pkg::MDU_DIV;
          mdu_a = mdu_res;
          mdu_b = MW'(rng_mag);
        end
      end
      arr_pkg::ST_CURVE: begin
        case (curve)
          arr_pkg::CRV_LIN, arr_pkg::CRV_OFFSET: ;
          arr_pkg::CRV_AUTO: begin
            mdu_req.start = 1'b1;
            mdu_a = DW'(x_mag);
            mdu_b = arr_pkg::LN_INV09_Q;
          end
          default: begin
            mdu_req.start = 1'b1;
            mdu_a = DW'(x_mag);
            mdu_b = MW'(k_mag);
          end
        endcase
      end
      arr_pkg::ST_LOG_START: begin
        mdu_req.start = 1'b1;
        mdu_a = DW'(t_mag_q);
        mdu_b = arr_pkg::LOG2E_Q;
      end
      arr_pkg::ST_GAIN_START: begin
        mdu_req.start = 1'b1;
        mdu_a = DW'(inner_mag);
        mdu_b = MW'(gain_q);
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = (state_q == arr_pkg::ST_IDLE);
  assign cfg_ready_o     = 1'b1;

  // control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      gain_q      <= arr_pkg::GAIN_RST;
      out_min_q   <= arr_pkg::OUT_MIN_RST;
      out_max_q   <= arr_pkg::OUT_MAX_RST;
      curve_q     <= arr_pkg::CURVE_RST;
      offset_q    <= arr_pkg::OFFSET_RST;
      mode_q      <= arr_pkg::MODE_RST;
      seen_min_q  <= arr_pkg::START_MIN_RST;
      seen_max_q  <= arr_pkg::START_MAX_RST;
    end else begin
      state_q <= state_d;
      if (state_q == arr_pkg::ST_FINISH && (!out_valid_q || m_axis_tready_i)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s_acc) begin
        seen_min_q <= new_min;
        seen_max_q <= new_max;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (arr_pkg::cfg_reg_e'(cfg_index_i))
          arr_pkg::CFG_GAIN:    gain_q    <= cfg_data_i[30:0];
          arr_pkg::CFG_OUT_MIN: out_min_q <= $signed(cfg_data_i);
          arr_pkg::CFG_OUT_MAX: out_max_q <= $signed(cfg_data_i);
          arr_pkg::CFG_CURVE:   curve_q   <= $signed(cfg_data_i);
          arr_pkg::CFG_OFFSET:  offset_q  <= $signed(cfg_data_i);
          arr_pkg::CFG_MODE:    mode_q    <= cfg_data_i[4:0];
          arr_pkg::CFG_START_MIN: begin
            seen_min_q  <= $signed(cfg_data_i);
          end
          arr_pkg::CFG_START_MAX: begin
            seen_max_q  <= $signed(cfg_data_i);
          end
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      arr_pkg::ST_IDLE: begin
        if (s_acc) s_q <= s_in;
      end
      arr_pkg::ST_RANGE: begin
        res_q   <= '0;
        empty_q <= (rng == '0);
      end
      arr_pkg::ST_SCALE_DIV: begin
        if (mdu_rsp.done) x_q <= x_sat;
      end
      arr_pkg::ST_CURVE: begin
        if (curve == arr_pkg::CRV_LIN) inner_q <= 34'(x_q);
        else inner_q <= c_ext + 34'(x_q);
      end
      arr_pkg::ST_T_MUL: begin
        if (mdu_rsp.done) begin
          t_neg_q <= curve_q[31] ^ x_q[31];
          t_mag_q <= (rmag > 52'h2_0000_0000) ? 34'h2_0000_0000 : rmag[33:0];
        end
      end
      arr_pkg::ST_K_DIV: begin
        if (mdu_rsp.done) begin
          t_neg_q <= x_q[31] ^ rng[32];
          t_mag_q <= (q_cap > 41'h2_0000_0000) ? 34'h2_0000_0000 : q_cap[33:0];
        end
      end
      arr_pkg::ST_LOG_MUL: begin
        if (mdu_rsp.done) begin
          u_q <= t_neg_q ? -$signed({1'b0, rmag[34:0]}) : $signed({1'b0, rmag[34:0]});
        end
      end
      arr_pkg::ST_ROM: begin
        rom_q <= exp_rom[u_q[15 -: EXP_TABLE_BITS]];
      end
      arr_pkg::ST_EXP: begin
        case (curve)
          arr_pkg::CRV_EXP:     inner_q <= e_ext;
          arr_pkg::CRV_OFF_EXP: inner_q <= c_ext + 34'sd65536 - e_ext;
          default:              inner_q <= c_ext - e_ext;
        endcase
      end
      arr_pkg::ST_GAIN_MUL: begin
        if (mdu_rsp.done) begin
          empty_q <= 1'b0;
          if (inner_q[33]) begin
            res_q <= (rmag > 52'h8000_0000) ? 32'h8000_0000 : 32'(-rmag[31:0]);
          end else begin
            res_q <= (rmag > 52'h7fff_ffff) ? 32'h7fff_ffff : rmag[31:0];
          end
        end
      end
      arr_pkg::ST_FINISH: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_data_q <= res_q;
          out_user_q <= empty_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_user_q;

  a_mdu_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_req.start |-> !mdu_rsp.busy)
    else $error("shared unit restarted while busy");

  a_mdu_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_rsp.done |-> (state_q == arr_pkg::ST_SCALE_MUL || state_q == arr_pkg::ST_SCALE_DIV ||
                      state_q == arr_pkg::ST_T_MUL || state_q == arr_pkg::ST_K_MUL ||
                      state_q == arr_pkg::ST_K_DIV || state_q == arr_pkg::ST_LOG_MUL ||
                      state_q == arr_pkg::ST_GAIN_MUL))
    else $error("shared unit finished outside a wait state");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("empty range word with nonzero response");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("input taken again before the word finished");

endmodule

// ===== rtl/core/arr_mdu.sv =====
// ----------------------------------------------------------------------------
// arr_mdu - shared multiply / divide unit
// Shift-add multiply (one bit a cycle) and restoring divide on one adder.
// ----------------------------------------------------------------------------
module arr_mdu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  arr_pkg::mdu_req_t          req_i,
  input  logic [arr_pkg::DIV_W-1:0]  a_i,
  input  logic [arr_pkg::MUL_W-1:0]  b_i,
  output arr_pkg::mdu_rsp_t          rsp_o,
  output logic [arr_pkg::DIV_W-1:0]  res_o
);

  localparam int unsigned MW = arr_pkg::MUL_W;
  localparam int unsigned DW = arr_pkg::DIV_W;
  localparam int unsigned CW = arr_pkg::CNT_W;

  logic [MW:0]     acc_q, acc_d;
  logic [DW-1:0]   sh_q, sh_d;
  logic [MW-1:0]   b_q, b_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  arr_pkg::mdu_op_e op_q, op_d;

  logic [MW:0]     opx;
  logic [MW+1:0]   sum;
  logic [MW-1:0]   addend;
  logic            ge;

  always_comb begin
    addend = sh_q[0] ? b_q : '0;
    if (op_q == arr_pkg::MDU_DIV) begin
      opx = {acc_q[MW-1:0], sh_q[DW-1]};
      sum = {1'b0, opx} + ~{2'b00, b_q} + (MW+2)'(1);
    end else begin
      opx = {1'b0, acc_q[MW-1:0]};
      sum = {1'b0, opx} + {2'b00, addend};
    end
    ge = ~sum[MW+1];
  end

  always_comb begin
    acc_d  = acc_q;
    sh_d   = sh_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    op_d   = op_q;
    done_d = 1'b0;
    if (req_i.start) begin
      acc_d  = '0;
      sh_d   = a_i;
      b_d    = b_i;
      op_d   = req_i.op;
      cnt_d  = (req_i.op == arr_pkg::MDU_DIV) ? CW'(DW) : CW'(MW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      if (op_q == arr_pkg::MDU_DIV) begin
        acc_d = ge ? sum[MW:0] : opx;
        sh_d  = {sh_q[DW-2:0], ge};
      end else begin
        acc_d = {1'b0, sum[MW:1]};
        sh_d  = {sh_q[DW-1:MW], sum[0], sh_q[MW-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= arr_pkg::MDU_MUL;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    b_q   <= b_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign res_o = (op_q == arr_pkg::MDU_DIV) ? sh_q : {acc_q[MW-1:0], sh_q[MW-1:0]};

endmodule
